// ----- hdl/multi_turn_angle_velocity_tracker_core_macros.svh -----
// ----------------------------------------------------------------------------
// Multi-turn angle tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef MULTI_TURN_ANGLE_VELOCITY_TRACKER_CORE_MACROS_SVH
`define MULTI_TURN_ANGLE_VELOCITY_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTAVT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed");

// Next-cycle implication, disabled during reset
`define MTAVT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed");

`endif

// ----- hdl/mtavt_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-turn angle tracker package
// Widths, register indexes, reset values and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtavt_pkg;

   // Core sizing
   localparam int RAW_BITS      = 15;
   localparam int POSITION_BITS = 26;

   // Fixed field and register widths
   localparam int RAW_FIELD_BITS = 15;
   localparam int TICKS_BITS     = 16;
   localparam int CPR_BITS       = 16;
   localparam int WRAP_BITS      = 15;
   localparam int LIMIT_BITS     = 10;
   localparam int TURN_BITS      = 11;
   localparam int VEL_BITS       = 32;
   localparam int FRAC_BITS      = 8;

   // Derived widths
   localparam int NUM_BITS        = POSITION_BITS + FRAC_BITS;
   localparam int Q_EXT_BITS      = (NUM_BITS > VEL_BITS + 1) ? NUM_BITS : VEL_BITS + 1;
   localparam int DIV_CNT_BITS    = $clog2(NUM_BITS + 1);
   localparam int DIFF_BITS       = RAW_BITS + 1;
   localparam int WRAP_CMP_BITS   = (DIFF_BITS > WRAP_BITS) ? DIFF_BITS : WRAP_BITS;
   localparam int STEP_BITS       = TURN_BITS + 1;
   localparam int SHIFT_PROD_BITS = LIMIT_BITS + CPR_BITS;
   localparam int POS_PROD_BITS   = TURN_BITS + CPR_BITS + 1;
   localparam int WIDE_BITS       =
      ((POSITION_BITS > POS_PROD_BITS) ? POSITION_BITS : POS_PROD_BITS) + 1;

   // Stream widths
   localparam int REQ_DATA_BITS = ((RAW_FIELD_BITS + TICKS_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((POSITION_BITS + TURN_BITS + VEL_BITS + 7) / 8) * 8;

   // Control register port
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_COUNTS_PER_REV     = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WRAP_THRESHOLD     = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TURN_LIMIT         = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_INTERVAL_TICKS = 2'd3;

   localparam logic [CPR_BITS-1:0]   CPR_RESET       = 16'd4096;
   localparam logic [WRAP_BITS-1:0]  WRAP_RESET      = 15'd3276;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET     = 10'd1000;
   localparam logic [TICKS_BITS-1:0] MAX_TICKS_RESET = 16'd500;

   // Velocity saturation bounds
   localparam logic [Q_EXT_BITS-1:0] VEL_NEG_MAG = Q_EXT_BITS'(64'h8000_0000);
   localparam logic [Q_EXT_BITS-1:0] VEL_POS_MAG = Q_EXT_BITS'(64'h7FFF_FFFF);
   localparam logic [VEL_BITS-1:0]   VEL_NEG_SAT = 32'h8000_0000;
   localparam logic [VEL_BITS-1:0]   VEL_POS_SAT = 32'h7FFF_FFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic unwrap;
      logic position;
      logic diff_start;
      logic load;
   } mtavt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
      logic out_free;
   } mtavt_sts_type;

endpackage

`default_nettype wire

// ----- hdl/mtavt_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtavt_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [mtavt_pkg::NUM_BITS-1:0]     dividend,
   input  wire logic [mtavt_pkg::TICKS_BITS-1:0]   divisor,
   output logic                                    done,
   output logic [mtavt_pkg::NUM_BITS-1:0]          quotient
);

   logic [mtavt_pkg::NUM_BITS-1:0]     quo_ff;
   logic [mtavt_pkg::NUM_BITS-1:0]     quo_in;
   logic [mtavt_pkg::TICKS_BITS-1:0]   rem_ff;
   logic [mtavt_pkg::TICKS_BITS-1:0]   rem_in;
   logic [mtavt_pkg::TICKS_BITS-1:0]   divisor_ff;
   logic [mtavt_pkg::DIV_CNT_BITS-1:0] cnt_ff;
   logic                               busy_ff;
   logic                               done_ff;
   logic [mtavt_pkg::TICKS_BITS:0]     trial;
   logic [mtavt_pkg::TICKS_BITS:0]     trial_sub;
   logic                               ge;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      trial     = {rem_ff, quo_ff[mtavt_pkg::NUM_BITS-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      ge        = (trial >= {1'b0, divisor_ff});
      rem_in    = ge ? trial_sub[mtavt_pkg::TICKS_BITS-1:0]
                     : trial[mtavt_pkg::TICKS_BITS-1:0];
      quo_in    = {quo_ff[mtavt_pkg::NUM_BITS-2:0], ge};
   end

   // Hold operands and advance one bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Count iterations and flag completion
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mtavt_pkg::DIV_CNT_BITS'(mtavt_pkg::NUM_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == mtavt_pkg::DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/mtavt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tracker controller
// Sequences unwrap, position, difference, divide and result load per sample.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_turn_angle_velocity_tracker_core_macros.svh"

module mtavt_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire mtavt_pkg::mtavt_sts_type sts_i,
   output mtavt_pkg::mtavt_cmd_type      cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TURN,
      S_POS,
      S_DIFF,
      S_DIV,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   // Step through one sample
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_TURN;
                  ready_ff <= 1'b0;
               end
            end
            S_TURN: begin
               state_ff <= S_POS;
            end
            S_POS: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (sts_i.div_done) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (sts_i.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   // Decode datapath commands
   always_comb begin
      cmd_o            = '0;
      cmd_o.capture    = accept && (state_ff == S_IDLE);
      cmd_o.unwrap     = (state_ff == S_TURN);
      cmd_o.position   = (state_ff == S_POS);
      cmd_o.diff_start = (state_ff == S_DIFF);
      cmd_o.load       = (state_ff == S_LOAD) && sts_i.out_free;
   end

   assign req_tready = ready_ff;

   `MTAVT_ASSERT_NXT(a_accept_blocks, clock, reset, req_tvalid && req_tready, !req_tready)
   `MTAVT_ASSERT_IMP(a_load_needs_room, clock, reset, cmd_o.load, sts_i.out_free)
   `MTAVT_ASSERT_IMP(a_done_in_div, clock, reset, sts_i.div_done, state_ff == S_DIV)

endmodule

`default_nettype wire

// ----- hdl/mtavt_dp.sv -----
// ----------------------------------------------------------------------------
// Tracker datapath
// Control registers, turn unwrap, position, velocity divide and result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module mtavt_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [mtavt_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [mtavt_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic [mtavt_pkg::RAW_FIELD_BITS-1:0]   raw_count,
   input  wire logic [mtavt_pkg::TICKS_BITS-1:0]       interval_ticks,
   input  wire logic                                   rsp_tready,
   output logic                                        rsp_tvalid,
   output logic signed [mtavt_pkg::POSITION_BITS-1:0]  position_counts,
   output logic signed [mtavt_pkg::TURN_BITS-1:0]      turn_count,
   output logic signed [mtavt_pkg::VEL_BITS-1:0]       velocity_q8,
   output logic                                        turns_rebased,
   input  wire mtavt_pkg::mtavt_cmd_type               cmd_i,
   output mtavt_pkg::mtavt_sts_type                    sts_o
);

   // Control registers
   logic [mtavt_pkg::CPR_BITS-1:0]   cpr_ff;
   logic [mtavt_pkg::WRAP_BITS-1:0]  wrap_ff;
   logic [mtavt_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [mtavt_pkg::TICKS_BITS-1:0] max_ticks_ff;

   // Tracking state
   logic [mtavt_pkg::RAW_BITS-1:0]             prev_raw_ff;
   logic signed [mtavt_pkg::TURN_BITS-1:0]     turns_ff;
   logic signed [mtavt_pkg::TURN_BITS-1:0]     turns_in;
   logic [mtavt_pkg::POSITION_BITS-1:0]        prev_pos_ff;
   logic [mtavt_pkg::POSITION_BITS-1:0]        prev_pos_in;

   // Per-sample working registers
   logic [mtavt_pkg::RAW_BITS-1:0]      raw_ff;
   logic [mtavt_pkg::TICKS_BITS-1:0]    ticks_ff;
   logic [mtavt_pkg::TICKS_BITS-1:0]    ticks_in;
   logic [mtavt_pkg::POSITION_BITS-1:0] pos_ff;
   logic [mtavt_pkg::POSITION_BITS-1:0] pos_in;
   logic [mtavt_pkg::POSITION_BITS-1:0] shift_ff;
   logic [mtavt_pkg::POSITION_BITS-1:0] shift_in;
   logic                                rebased_ff;
   logic                                rebased_in;
   logic                                neg_ff;

   // Result register
   logic                                       rsp_valid_ff;
   logic signed [mtavt_pkg::POSITION_BITS-1:0] rsp_pos_ff;
   logic signed [mtavt_pkg::TURN_BITS-1:0]     rsp_turn_ff;
   logic signed [mtavt_pkg::VEL_BITS-1:0]      rsp_vel_ff;
   logic                                       rsp_rebased_ff;
   logic [mtavt_pkg::VEL_BITS-1:0]             vel_in;

   // Combinational helpers
   logic signed [mtavt_pkg::DIFF_BITS-1:0]     raw_diff;
   logic [mtavt_pkg::DIFF_BITS-1:0]            raw_mag;
   logic                                       wrapped;
   logic signed [mtavt_pkg::STEP_BITS-1:0]     turns_step;
   logic signed [mtavt_pkg::STEP_BITS-1:0]     lim_ext;
   logic                                       hit_high;
   logic                                       hit_low;
   logic [mtavt_pkg::SHIFT_PROD_BITS-1:0]      shift_prod;
   logic signed [mtavt_pkg::POS_PROD_BITS-1:0] pos_prod;
   logic signed [mtavt_pkg::WIDE_BITS-1:0]     pos_sum;
   logic [mtavt_pkg::POSITION_BITS-1:0]        pos_diff;
   logic [mtavt_pkg::POSITION_BITS-1:0]        pos_mag;
   logic [mtavt_pkg::NUM_BITS-1:0]             dividend;
   logic                                       div_done;
   logic [mtavt_pkg::NUM_BITS-1:0]             quotient;
   logic [mtavt_pkg::Q_EXT_BITS-1:0]           q_ext;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff       <= mtavt_pkg::CPR_RESET;
         wrap_ff      <= mtavt_pkg::WRAP_RESET;
         limit_ff     <= mtavt_pkg::LIMIT_RESET;
         max_ticks_ff <= mtavt_pkg::MAX_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            mtavt_pkg::CSR_COUNTS_PER_REV: begin
               cpr_ff <= csr_wdata[mtavt_pkg::CPR_BITS-1:0];
            end
            mtavt_pkg::CSR_WRAP_THRESHOLD: begin
               wrap_ff <= csr_wdata[mtavt_pkg::WRAP_BITS-1:0];
            end
            mtavt_pkg::CSR_TURN_LIMIT: begin
               limit_ff <= csr_wdata[mtavt_pkg::LIMIT_BITS-1:0];
            end
            mtavt_pkg::CSR_MAX_INTERVAL_TICKS: begin
               max_ticks_ff <= csr_wdata[mtavt_pkg::TICKS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Rebase offset tracks the configuration
   assign shift_prod = limit_ff * cpr_ff;
   assign shift_in   = mtavt_pkg::POSITION_BITS'(shift_prod);

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // Detect rollover, apply the turn limit and clamp the interval
   always_comb begin
      raw_diff   = $signed({1'b0, raw_ff}) - $signed({1'b0, prev_raw_ff});
      raw_mag    = raw_diff[mtavt_pkg::DIFF_BITS-1] ? mtavt_pkg::DIFF_BITS'(-raw_diff)
                                                    : mtavt_pkg::DIFF_BITS'(raw_diff);
      wrapped    = (mtavt_pkg::WRAP_CMP_BITS'(raw_mag) > mtavt_pkg::WRAP_CMP_BITS'(wrap_ff));
      turns_step = mtavt_pkg::STEP_BITS'(turns_ff);
      if (wrapped) begin
         if (raw_diff[mtavt_pkg::DIFF_BITS-1]) begin
            turns_step = turns_step + mtavt_pkg::STEP_BITS'(1);
         end else begin
            turns_step = turns_step - mtavt_pkg::STEP_BITS'(1);
         end
      end
      lim_ext    = $signed(mtavt_pkg::STEP_BITS'(limit_ff));
      hit_high   = (turns_step >= lim_ext);
      hit_low    = (turns_step <= -lim_ext);
      rebased_in = hit_high || hit_low;
      turns_in   = rebased_in ? '0 : turns_step[mtavt_pkg::TURN_BITS-1:0];
      if (hit_high) begin
         prev_pos_in = prev_pos_ff - shift_ff;
      end else if (hit_low) begin
         prev_pos_in = prev_pos_ff + shift_ff;
      end else begin
         prev_pos_in = prev_pos_ff;
      end
      if ((ticks_ff == '0) || (ticks_ff > max_ticks_ff)) begin
         ticks_in = mtavt_pkg::TICKS_BITS'(1);
      end else begin
         ticks_in = ticks_ff;
      end
   end

   // Multi-turn position from turns and raw count
   assign pos_prod = turns_ff * $signed({1'b0, cpr_ff});
   assign pos_sum  = mtavt_pkg::WIDE_BITS'(pos_prod) + $signed(mtavt_pkg::WIDE_BITS'(raw_ff));
   assign pos_in   = pos_sum[mtavt_pkg::POSITION_BITS-1:0];

   // Wrapped position change as sign and magnitude
   assign pos_diff = pos_ff - prev_pos_ff;
   assign pos_mag  = pos_diff[mtavt_pkg::POSITION_BITS-1] ? (~pos_diff + 1'b1) : pos_diff;
   assign dividend = {pos_mag, {mtavt_pkg::FRAC_BITS{1'b0}}};

   // Sample working registers
   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         raw_ff   <= mtavt_pkg::RAW_BITS'(raw_count);
         ticks_ff <= interval_ticks;
      end
      if (cmd_i.unwrap) begin
         ticks_ff   <= ticks_in;
         rebased_ff <= rebased_in;
      end
      if (cmd_i.position) begin
         pos_ff <= pos_in;
      end
      if (cmd_i.diff_start) begin
         neg_ff <= pos_diff[mtavt_pkg::POSITION_BITS-1];
      end
   end

   // Tracking state across samples
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= '0;
         turns_ff    <= '0;
         prev_pos_ff <= '0;
      end else begin
         if (cmd_i.unwrap) begin
            prev_raw_ff <= raw_ff;
            turns_ff    <= turns_in;
            prev_pos_ff <= prev_pos_in;
         end
         if (cmd_i.diff_start) begin
            prev_pos_ff <= pos_ff;
         end
      end
   end

   mtavt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd_i.diff_start),
      .dividend (dividend),
      .divisor  (ticks_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Saturate the quotient to a signed velocity
   always_comb begin
      q_ext = mtavt_pkg::Q_EXT_BITS'(quotient);
      if (neg_ff) begin
         if (q_ext > mtavt_pkg::VEL_NEG_MAG) begin
            vel_in = mtavt_pkg::VEL_NEG_SAT;
         end else begin
            vel_in = ~q_ext[mtavt_pkg::VEL_BITS-1:0] + 1'b1;
         end
      end else begin
         if (q_ext > mtavt_pkg::VEL_POS_MAG) begin
            vel_in = mtavt_pkg::VEL_POS_SAT;
         end else begin
            vel_in = q_ext[mtavt_pkg::VEL_BITS-1:0];
         end
      end
   end

   // Hold the result until the transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         rsp_pos_ff     <= pos_ff;
         rsp_turn_ff    <= turns_ff;
         rsp_vel_ff     <= vel_in;
         rsp_rebased_ff <= rebased_ff;
      end
   end

   assign sts_o.div_done  = div_done;
   assign sts_o.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid      = rsp_valid_ff;
   assign position_counts = rsp_pos_ff;
   assign turn_count      = rsp_turn_ff;
   assign velocity_q8     = rsp_vel_ff;
   assign turns_rebased   = rsp_rebased_ff;

endmodule

`default_nettype wire

// ----- hdl/multi_turn_angle_velocity_tracker_core.sv -----
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker
// Unwraps single-turn encoder counts into a multi-turn position and derives
// a Q8 velocity in counts per tick.
// ----------------------------------------------------------------------------
// From acceptance, each sample passes through rollover detection, position
// and difference, then the bit-serial velocity divider, which retires one
// quotient bit per cycle, then completion, result load and return to idle
// before the next sample can be accepted. The finished result sits in an
// output register, so a new sample may enter while it waits.
// Velocity is the wrapped position change times 256 divided by the interval,
// truncated toward zero and saturated to 32 bits; an interval of zero or one
// above max_interval_ticks counts as one tick. Write control registers only
// while no sample is in flight.
`default_nettype none

module multi_turn_angle_velocity_tracker_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Control registers
   input  wire logic                                  csr_we,
   input  wire logic [mtavt_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [mtavt_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   // Sample stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // raw_count, interval_ticks
   input  wire logic [mtavt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Result stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // position_counts, turn_count, velocity_q8
   output logic [mtavt_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // turns_rebased
   output logic                                       rsp_tuser
);

   mtavt_pkg::mtavt_cmd_type cmd;
   mtavt_pkg::mtavt_sts_type sts;

   logic [mtavt_pkg::RAW_FIELD_BITS-1:0]       raw_count;
   logic [mtavt_pkg::TICKS_BITS-1:0]           interval_ticks;
   logic signed [mtavt_pkg::POSITION_BITS-1:0] position_counts;
   logic signed [mtavt_pkg::TURN_BITS-1:0]     turn_count;
   logic signed [mtavt_pkg::VEL_BITS-1:0]      velocity_q8;

   // Unpack the sample
   assign raw_count      = req_tdata[mtavt_pkg::RAW_FIELD_BITS-1:0];
   assign interval_ticks = req_tdata[mtavt_pkg::RAW_FIELD_BITS +: mtavt_pkg::TICKS_BITS];

   mtavt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   mtavt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .raw_count       (raw_count),
      .interval_ticks  (interval_ticks),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .position_counts (position_counts),
      .turn_count      (turn_count),
      .velocity_q8     (velocity_q8),
      .turns_rebased   (rsp_tuser),
      .cmd_i           (cmd),
      .sts_o           (sts)
   );

   // Pack the result, zero-filled to whole bytes
   assign rsp_tdata = mtavt_pkg::RSP_DATA_BITS'({velocity_q8, turn_count, position_counts});

endmodule

`default_nettype wire
